[rtl/pt64_pkg.sv]
`timescale 1ns / 1ps
package pt64_pkg;
  localparam int PRIME_COUNT = 25;
  localparam int WIDTH_DEF = 64;
  localparam int WITNESS_LIMIT_DEF = 41;
  localparam int TRIAL_LIMIT_DEF = 100;

  // decided_by codes
  localparam logic [1:0] DEC_SMALL = 2'd0;
  localparam logic [1:0] DEC_TRIAL = 2'd1;
  localparam logic [1:0] DEC_WITNESS = 2'd2;

  // primes below 100, index 0..24
  function automatic logic [6:0] prime_at(input logic [4:0] idx);
    logic [6:0] p;
    case (idx)
      5'd0: p = 7'd2;   5'd1: p = 7'd3;   5'd2: p = 7'd5;   5'd3: p = 7'd7;
      5'd4: p = 7'd11;  5'd5: p = 7'd13;  5'd6: p = 7'd17;  5'd7: p = 7'd19;
      5'd8: p = 7'd23;  5'd9: p = 7'd29;  5'd10: p = 7'd31; 5'd11: p = 7'd37;
      5'd12: p = 7'd41; 5'd13: p = 7'd43; 5'd14: p = 7'd47; 5'd15: p = 7'd53;
      5'd16: p = 7'd59; 5'd17: p = 7'd61; 5'd18: p = 7'd67; 5'd19: p = 7'd71;
      5'd20: p = 7'd73; 5'd21: p = 7'd79; 5'd22: p = 7'd83; 5'd23: p = 7'd89;
      5'd24: p = 7'd97;
      default: p = 7'd127;
    endcase
    return p;
  endfunction

  // number of table primes below a limit
  function automatic int count_below(input int lim);
    int c;
    c = 0;
    for (int i = 0; i < PRIME_COUNT; i++) begin
      if (int'(prime_at(5'(i))) < lim) c++;
    end
    return c;
  endfunction
endpackage

[rtl/pt64_modmul.sv]
`timescale 1ns / 1ps
// Bit-serial modular multiplier: r = a*b mod n, one bit of b per cycle,
// MSB first (double then conditional add).
module pt64_modmul #(
  parameter int WIDTH = pt64_pkg::WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic [WIDTH-1:0] n,
  output logic             done,
  output logic [WIDTH-1:0] r
);
  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] areg, breg, nreg, acc;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [WIDTH:0]   dbl, dbl_m, add, add_m;
  logic [WIDTH-1:0] step1, step2;

  // one double-and-add step, each add followed by one compare/subtract
  always_comb begin
    dbl   = {acc, 1'b0};
    dbl_m = dbl - {1'b0, nreg};
    step1 = (dbl >= {1'b0, nreg}) ? dbl_m[WIDTH-1:0] : dbl[WIDTH-1:0];
    add   = {1'b0, step1} + {1'b0, areg};
    add_m = add - {1'b0, nreg};
    step2 = breg[WIDTH-1] ? ((add >= {1'b0, nreg}) ? add_m[WIDTH-1:0]
                                                   : add[WIDTH-1:0]) : step1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        areg <= a;
        breg <= b;
        nreg <= n;
        acc  <= '0;
        cnt  <= CW'(WIDTH);
      end else if (busy) begin
        acc  <= step2;
        breg <= {breg[WIDTH-2:0], 1'b0};
        cnt  <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign r = acc;
endmodule

[rtl/pt64_trial.sv]
`timescale 1ns / 1ps
// Bit-serial remainder of x by a small prime: one bit of x per cycle,
// MSB first, remainder stays below the prime.
module pt64_trial #(
  parameter int WIDTH = pt64_pkg::WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] x,
  input  logic [6:0]       p,
  output logic             done,
  output logic             divisible
);
  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] xs;
  logic [6:0]       rem, pr;
  logic [7:0]       t;
  logic [CW-1:0]    cnt;
  logic             busy;

  always_comb begin
    t = {rem, xs[WIDTH-1]};
    if (t >= {1'b0, pr}) t = t - {1'b0, pr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        xs   <= x;
        pr   <= p;
        rem  <= '0;
        cnt  <= CW'(WIDTH);
      end else if (busy) begin
        rem <= t[6:0];
        xs  <= {xs[WIDTH-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign divisible = (rem == 7'd0);
endmodule

[rtl/primality_test_64.sv]
`timescale 1ns / 1ps
// primality_test_64: deterministic Miller-Rabin test of one unsigned number.
// Input channel s_axis_*: tdata carries the candidate; a transfer starts a
// test. Output channel m_axis_*: one transfer per candidate with is_prime
// and decided_by. Only one candidate is in flight; s_axis_tready is high
// while the block is idle and its output register is free.
// Values below 5 are decided directly in IDLE. Trial division runs once per
// prime below TRIAL_LIMIT. Each witness round needs about 2*WIDTH modular
// products for the power plus up to s squarings, all on one shared
// bit-serial multiplier; a prime runs all twelve witnesses at the default
// WITNESS_LIMIT. Composites stop at the first failing stage.
// Reset (rst, synchronous) returns the sequencer to idle and drops any
// pending result. While the receiver stalls the result is held in the
// output register and no new candidate is taken.
module primality_test_64 #(
  parameter int WIDTH = pt64_pkg::WIDTH_DEF,
  parameter int WITNESS_LIMIT = pt64_pkg::WITNESS_LIMIT_DEF,
  parameter int TRIAL_LIMIT = pt64_pkg::TRIAL_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] candidate
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [0] is_prime, [2:1] decided_by, rest 0
);
  localparam int NTRIAL = pt64_pkg::count_below(TRIAL_LIMIT);
  localparam int NWIT = pt64_pkg::count_below(WITNESS_LIMIT);
  localparam int SW = $clog2(WIDTH + 1);

  typedef enum logic [3:0] {
    IDLE, TRIAL_GO, TRIAL_WAIT, SPLIT, WIT_SETUP, POW_BIT, POW_MUL_WAIT,
    POW_SQR_WAIT, CHECK, SQR_WAIT, FINISH
  } state_t;

  state_t           state;
  logic [WIDTH-1:0] x, d, e, base, y, nm1;
  logic [SW-1:0]    s, k;
  logic [4:0]       idx;
  logic             res_prime;
  logic [1:0]       res_dec;
  logic             out_valid;
  logic             mm_start, mm_done, tr_start, tr_done, tr_div;
  logic [WIDTH-1:0] mm_a, mm_b, mm_r, wit;
  logic [6:0]       pcur;
  logic [WIDTH-1:0] cand;

  assign cand = s_axis_tdata[WIDTH-1:0];
  assign pcur = pt64_pkg::prime_at(idx);
  assign s_axis_tready = (state == IDLE) && !out_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {5'd0, res_dec, res_prime};

  pt64_modmul #(.WIDTH(WIDTH)) u_mul (
    .clk(clk), .rst(rst), .start(mm_start), .a(mm_a), .b(mm_b), .n(x),
    .done(mm_done), .r(mm_r)
  );

  pt64_trial #(.WIDTH(WIDTH)) u_trial (
    .clk(clk), .rst(rst), .start(tr_start), .x(x), .p(pcur),
    .done(tr_done), .divisible(tr_div)
  );

  // witness residue: prime < 128 and x >= 5, so the quotient is below 32;
  // restoring steps with x shifted by 4..0 when x is small
  always_comb begin
    logic [WIDTH-1:0] pw;
    pw = WIDTH'(pcur);
    if (x < WIDTH'(128)) begin
      if (pw >= (x << 4)) pw = pw - (x << 4);
      if (pw >= (x << 3)) pw = pw - (x << 3);
      if (pw >= (x << 2)) pw = pw - (x << 2);
      if (pw >= (x << 1)) pw = pw - (x << 1);
      if (pw >= x) pw = pw - x;
    end
    wit = pw;
  end

  // sequencer and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      mm_start  <= 1'b0;
      tr_start  <= 1'b0;
      idx       <= '0;
    end else begin
      mm_start <= 1'b0;
      tr_start <= 1'b0;
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            x   <= cand;
            nm1 <= cand - 1'b1;
            idx <= '0;
            if (cand < WIDTH'(5)) begin
              res_prime <= (cand == WIDTH'(2)) || (cand == WIDTH'(3));
              res_dec   <= pt64_pkg::DEC_SMALL;
              out_valid <= 1'b1;
            end else begin
              state <= TRIAL_GO;
            end
          end
        end
        TRIAL_GO: begin
          if (int'(idx) >= NTRIAL) begin
            state <= SPLIT;
            d     <= nm1;
            s     <= '0;
          end else if (x == WIDTH'(pcur)) begin
            res_prime <= 1'b1;
            res_dec   <= pt64_pkg::DEC_TRIAL;
            state     <= FINISH;
          end else begin
            tr_start <= 1'b1;
            state    <= TRIAL_WAIT;
          end
        end
        TRIAL_WAIT: begin
          if (tr_done) begin
            if (tr_div) begin
              res_prime <= 1'b0;
              res_dec   <= pt64_pkg::DEC_TRIAL;
              state     <= FINISH;
            end else begin
              idx   <= idx + 1'b1;
              state <= TRIAL_GO;
            end
          end
        end
        // strip factors of two, one per cycle
        SPLIT: begin
          if (!d[0]) begin
            d <= d >> 1;
            s <= s + 1'b1;
          end else begin
            idx   <= '0;
            state <= WIT_SETUP;
          end
        end
        WIT_SETUP: begin
          if (int'(idx) >= NWIT) begin
            res_prime <= 1'b1;
            res_dec   <= pt64_pkg::DEC_WITNESS;
            state     <= FINISH;
          end else if (wit == '0) begin
            idx <= idx + 1'b1;
          end else begin
            base  <= wit;
            e     <= d;
            y     <= WIDTH'(1);
            state <= POW_BIT;
          end
        end
        // right-to-left square and multiply
        POW_BIT: begin
          if (e == '0) begin
            if (y == WIDTH'(1)) begin
              idx   <= idx + 1'b1;
              state <= WIT_SETUP;
            end else begin
              k     <= '0;
              state <= CHECK;
            end
          end else if (e[0]) begin
            mm_a     <= y;
            mm_b     <= base;
            mm_start <= 1'b1;
            state    <= POW_MUL_WAIT;
          end else begin
            mm_a     <= base;
            mm_b     <= base;
            mm_start <= 1'b1;
            state    <= POW_SQR_WAIT;
          end
        end
        POW_MUL_WAIT: begin
          if (mm_done) begin
            y        <= mm_r;
            mm_a     <= base;
            mm_b     <= base;
            mm_start <= 1'b1;
            state    <= POW_SQR_WAIT;
          end
        end
        POW_SQR_WAIT: begin
          if (mm_done) begin
            base  <= mm_r;
            e     <= e >> 1;
            state <= POW_BIT;
          end
        end
        // after s squarings the round has failed, whatever y holds
        CHECK: begin
          if (k >= s) begin
            res_prime <= 1'b0;
            res_dec   <= pt64_pkg::DEC_WITNESS;
            state     <= FINISH;
          end else if (y == nm1) begin
            idx   <= idx + 1'b1;
            state <= WIT_SETUP;
          end else begin
            mm_a     <= y;
            mm_b     <= y;
            mm_start <= 1'b1;
            state    <= SQR_WAIT;
          end
        end
        SQR_WAIT: begin
          if (mm_done) begin
            y     <= mm_r;
            k     <= k + 1'b1;
            state <= CHECK;
          end
        end
        FINISH: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // a held result keeps its value while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  // no input taken while a test is under way
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != IDLE |-> !s_axis_tready)
    else $error("ready while busy");
  // decided_by is never an undefined code
  a_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:1] != 2'd3)
    else $error("bad decided_by");
endmodule
